[sv/falu_pkg.sv]
// Shared types, codes and helpers for the fixed-point ALU.
package falu_pkg;

	localparam int FALU_FRAC_BITS   = 8;
	localparam int FALU_QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_MIN      = 4'd4,
		CMD_MAX      = 4'd5,
		CMD_INC      = 4'd6,
		CMD_DEC      = 4'd7,
		CMD_FROM_INT = 4'd8,
		CMD_TO_INT   = 4'd9,
		CMD_CMP      = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DONE,
		KIND_MUL,
		KIND_DIV
	} kind_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
		logic ovf;
		logic dz;
	} flags_t;

	typedef struct packed {
		kind_t       kind;
		logic        neg;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] res;
		flags_t      flags;
	} op_t;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	// {ovf, value}: signed saturation of a magnitude with a sign
	function automatic logic [32:0] sat_mag(input logic [63:0] mag, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (mag > 64'h0000_0000_8000_0000)
				r = {1'b1, S32_MIN};
			else
				r = {1'b0, 32'd0 - mag[31:0]};
		end else begin
			if (mag > 64'h0000_0000_7fff_ffff)
				r = {1'b1, S32_MAX};
			else
				r = {1'b0, mag[31:0]};
		end
		return r;
	endfunction

endpackage

[sv/falu_front.sv]
// Front stage: takes input beats, does the short operations, prepares mul/div.
module falu_front #(
	parameter int FRAC_BITS = falu_pkg::FALU_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [63:0]    s_tdata,   // operand_a, operand_b
	input  logic [3:0]     s_tuser,   // cmd
	output logic           op_valid,
	input  logic           op_ready,
	output falu_pkg::op_t  op
);
	import falu_pkg::*;

	logic [31:0]          a, b;
	cmd_t                 cmd;
	logic [32:0]          x, y, s;
	logic [31+FRAC_BITS:0] fi;
	logic                 fi_ok;
	op_t                  op_d;
	logic                 f_vld_q;
	op_t                  op_q;

	assign a   = s_tdata[31:0];
	assign b   = s_tdata[63:32];
	assign cmd = cmd_t'(s_tuser);
	assign x   = {a[31], a};

	always_comb begin
		case (cmd)
			CMD_SUB: y = 33'd0 - {b[31], b};
			CMD_INC: y = 33'd1;
			CMD_DEC: y = {33{1'b1}};
			default: y = {b[31], b};
		endcase
	end

	assign s     = x + y;
	assign fi    = {a, {FRAC_BITS{1'b0}}};
	assign fi_ok = (&fi[31+FRAC_BITS:31]) || !(|fi[31+FRAC_BITS:31]);

	always_comb begin
		op_d = '0;
		op_d.kind = KIND_DONE;
		unique case (cmd) inside
			CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
				if (s[32] != s[31]) begin
					op_d.flags.ovf = 1'b1;
					op_d.res       = s[32] ? S32_MIN : S32_MAX;
				end else begin
					op_d.res = s[31:0];
				end
			end
			CMD_MUL: begin
				op_d.kind = KIND_MUL;
				op_d.neg  = a[31] ^ b[31];
				op_d.ma   = mag32(a);
				op_d.mb   = mag32(b);
			end
			CMD_DIV: begin
				if (b == 32'd0) begin
					op_d.flags.dz = 1'b1;
				end else begin
					op_d.kind = KIND_DIV;
					op_d.neg  = a[31] ^ b[31];
					op_d.ma   = mag32(a);
					op_d.mb   = mag32(b);
				end
			end
			CMD_MIN: op_d.res = ($signed(a) < $signed(b)) ? a : b;
			CMD_MAX: op_d.res = ($signed(a) > $signed(b)) ? a : b;
			CMD_FROM_INT: begin
				if (fi_ok) begin
					op_d.res = fi[31:0];
				end else begin
					op_d.flags.ovf = 1'b1;
					op_d.res       = a[31] ? S32_MIN : S32_MAX;
				end
			end
			CMD_TO_INT: op_d.res = 32'($signed(a) >>> FRAC_BITS);
			CMD_CMP: begin
				op_d.flags.lt = $signed(a) < $signed(b);
				op_d.flags.eq = a == b;
				op_d.flags.gt = $signed(a) > $signed(b);
			end
			default: op_d = op_d;
		endcase
	end

	assign s_tready = !f_vld_q || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_q <= 1'b0;
		end else if (s_tready) begin
			f_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_q <= op_d;
		end
	end

	assign op_valid = f_vld_q;
	assign op       = op_q;

endmodule

[sv/falu_queue.sv]
// Short queue between front and back.
module falu_queue #(
	parameter int DEPTH = falu_pkg::FALU_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  falu_pkg::op_t in_op,
	output logic          out_valid,
	input  logic          out_ready,
	output falu_pkg::op_t out_op
);
	import falu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	op_t               mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic              push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_op    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_op;
	end

endmodule

[sv/falu_back.sv]
// Back pipeline: multiplier with rounding, one-bit-per-stage divider, output register.
module falu_back #(
	parameter int FRAC_BITS = falu_pkg::FALU_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_ready,
	input  falu_pkg::op_t op,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic [4:0]    m_tuser
);
	import falu_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	logic              adv;
	logic              vld_s  [NW];
	kind_t             kind_s [NW];
	logic              neg_s  [NW];
	logic [31:0]       rem_s  [NW];
	logic [NW-1:0]     nq_s   [NW];
	logic [31:0]       d_s    [NW];
	logic [31:0]       res_s  [NW];
	flags_t            flg_s  [NW];
	logic [31:0]       rem_n  [NW];
	logic [NW-1:0]     nq_n   [NW];
	logic [63:0]       prod_s1;
	logic [63:0]       rnd;
	logic [32:0]       mul_sat;
	logic              rbit;
	logic [NW:0]       qsum;
	logic [32:0]       div_sat;
	logic              out_vld_q;
	logic [31:0]       out_res_q;
	flags_t            out_flg_q;

	assign adv      = !out_vld_q || m_tready;
	assign op_ready = adv;

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [31:0]   rem_i, d_i;
		logic [NW-1:0] nq_i;
		logic [32:0]   t;
		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign nq_i  = {op.ma, {FRAC_BITS{1'b0}}};
			assign d_i   = op.mb;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign nq_i  = nq_s[k-1];
			assign d_i   = d_s[k-1];
		end
		assign t = {rem_i, nq_i[NW-1]};
		always_comb begin
			if (t >= {1'b0, d_i}) begin
				rem_n[k] = 32'(t - {1'b0, d_i});
				nq_n[k]  = {nq_i[NW-2:0], 1'b1};
			end else begin
				rem_n[k] = t[31:0];
				nq_n[k]  = {nq_i[NW-2:0], 1'b0};
			end
		end
	end

	assign rnd     = (prod_s1 + HALF) >> FRAC_BITS;
	assign mul_sat = sat_mag(rnd, neg_s[0]);

	assign rbit    = {rem_s[NW-1], 1'b0} >= {1'b0, d_s[NW-1]};
	assign qsum    = {1'b0, nq_s[NW-1]} + (NW+1)'(rbit);
	assign div_sat = sat_mag(64'(qsum), neg_s[NW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++)
				vld_s[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= op_valid;
			for (int i = 1; i < NW; i++)
				vld_s[i] <= vld_s[i-1];
			out_vld_q <= vld_s[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[0] <= op.kind;
			neg_s[0]  <= op.neg;
			d_s[0]    <= op.mb;
			res_s[0]  <= op.res;
			flg_s[0]  <= op.flags;
			prod_s1   <= 64'(op.ma) * 64'(op.mb);
			for (int i = 0; i < NW; i++) begin
				rem_s[i] <= rem_n[i];
				nq_s[i]  <= nq_n[i];
			end
			for (int i = 1; i < NW; i++) begin
				neg_s[i] <= neg_s[i-1];
				d_s[i]   <= d_s[i-1];
				if (i == 1 && kind_s[0] == KIND_MUL) begin
					kind_s[i] <= KIND_DONE;
					res_s[i]  <= mul_sat[31:0];
					flg_s[i]  <= {flg_s[0].lt, flg_s[0].eq, flg_s[0].gt, mul_sat[32],
						flg_s[0].dz};
				end else begin
					kind_s[i] <= kind_s[i-1];
					res_s[i]  <= res_s[i-1];
					flg_s[i]  <= flg_s[i-1];
				end
			end
			if (kind_s[NW-1] == KIND_DIV) begin
				out_res_q <= div_sat[31:0];
				out_flg_q <= {flg_s[NW-1].lt, flg_s[NW-1].eq, flg_s[NW-1].gt, div_sat[32],
					flg_s[NW-1].dz};
			end else begin
				out_res_q <= res_s[NW-1];
				out_flg_q <= flg_s[NW-1];
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_res_q;
	assign m_tuser  = {out_flg_q.dz, out_flg_q.ovf, out_flg_q.gt, out_flg_q.eq, out_flg_q.lt};

endmodule

[sv/fixed_point_alu.sv]
// Top level of the signed fixed-point ALU.
// Throughput: one beat per cycle without output stall; one quotient bit per divider stage.
// Front stage and queue decouple input acceptance from the back pipeline stall.
// Reset: arst_n clears all valid and pointer state asynchronously; no item survives it.
module fixed_point_alu #(
	parameter int FRAC_BITS   = falu_pkg::FALU_FRAC_BITS,
	parameter int QUEUE_DEPTH = falu_pkg::FALU_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  logic [3:0]  s_tuser,   // [3:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic [4:0]  m_tuser    // is_less, is_equal, is_greater, overflow, div_by_zero
);
	import falu_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready;
	op_t  f_op, q_op;

	falu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	falu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_op(f_op),
		.out_valid(q_valid), .out_ready(q_ready), .out_op(q_op)
	);

	falu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(q_valid), .op_ready(q_ready), .op(q_op),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

[sv/falu_checker.sv]
// Port-level checks for the fixed-point ALU, bound to the top level.
module falu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [4:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tuser[2:0]) <= 1)
		else $error("more than one compare flag");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != 3'b000) |-> m_tdata == 32'd0 && m_tuser[4:3] == 2'b00)
		else $error("compare beat with value or error flags");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tdata == 32'd0 && !m_tuser[3])
		else $error("divide by zero beat not zero");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result beat out of reset");

endmodule

bind fixed_point_alu falu_checker u_falu_checker (.*);

[tb/sv/testbench.sv]
// Self-checking stream testbench for the fixed-point ALU: random and directed beats, exact predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import falu_pkg::*;

	localparam int FB = FALU_FRAC_BITS;
	localparam int N_RANDOM = 700;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [31:0] a;
		logic [31:0] b;
	} alu_op_t;

	typedef struct packed {
		logic [31:0] value;
		logic [4:0]  flags;
	} alu_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [4:0]  m_tuser;

	alu_op_t  pending_ops[$];
	alu_res_t expected_results[$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  stim_done = 1'b0;
	bit  sender_hold = 1'b0;
	bit  receiver_hold = 1'b0;
	int  send_gap = 0;
	int  recv_gap = 0;

	fixed_point_alu DUT (.*);

	always #5 clk = ~clk;

	function automatic longint sat32(input longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic alu_res_t alu_predict(input alu_op_t op);
		longint x, y, r, p;
		longint unsigned m, n, d, q;
		bit ovf, dz, lt, eq, gt;
		alu_res_t o;
		x = longint'(signed'(op.a));
		y = longint'(signed'(op.b));
		r = 0;
		ovf = 0; dz = 0; lt = 0; eq = 0; gt = 0;
		case (cmd_t'(op.cmd))
			CMD_ADD: r = sat32(x + y, ovf);
			CMD_SUB: r = sat32(x - y, ovf);
			CMD_MUL: begin
				p = x * y;
				m = p < 0 ? -p : p;
				m = (m + (64'd1 << (FB - 1))) >> FB;
				r = sat32(p < 0 ? -longint'(m) : longint'(m), ovf);
			end
			CMD_DIV: begin
				if (y == 0) dz = 1'b1;
				else begin
					n = (x < 0 ? -x : x) << FB;
					d = y < 0 ? -y : y;
					q = (2 * n + d) / (2 * d);
					r = sat32(((x < 0) != (y < 0)) ? -longint'(q) : longint'(q), ovf);
				end
			end
			CMD_MIN: r = x < y ? x : y;
			CMD_MAX: r = x > y ? x : y;
			CMD_INC: r = sat32(x + 1, ovf);
			CMD_DEC: r = sat32(x - 1, ovf);
			CMD_FROM_INT: r = sat32(x * (64'sd1 <<< FB), ovf);
			CMD_TO_INT: r = x >>> FB;
			CMD_CMP: begin
				lt = x < y; eq = x == y; gt = x > y;
			end
			default: r = 0;
		endcase
		o.value = r[31:0];
		o.flags = {dz, ovf, gt, eq, lt};
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 2) == 0 ? S32_MAX : S32_MIN;
			1: return 32'(int'($urandom_range(0, 8)) - 4);
			2: return 32'(int'($urandom_range(0, 16'hffff)) - 32768);
			3: return 32'(int'($urandom_range(0, 24'hffffff)) - 24'h800000);
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_results.push_back(alu_predict({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
			void'(pending_ops.pop_front());
		end
		if (!arst_n || sender_hold) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_tready) begin
			s_tvalid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			s_tvalid <= 1'b0;
		end else if (pending_ops.size() > 0) begin
			s_tvalid <= 1'b1;
			{s_tuser, s_tdata[31:0], s_tdata[63:32]} <= pending_ops[0];
			send_gap <= rand_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		alu_res_t got, want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser};
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result beat %h/%b", m_tdata, m_tuser);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("result mismatch: expected %h/%b got %h/%b",
							want.value, want.flags, m_tdata, m_tuser);
				end
			end
		end
		if (!arst_n || receiver_hold) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			recv_gap <= rand_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// long receiver stall while the sender keeps offering
	initial begin
		int hold_cycles;
		hold_cycles = 0;
		wait (pending_ops.size() > 0 && pending_ops.size() < 650);
		receiver_hold = 1'b1;
		while (hold_cycles < 200) begin
			@(posedge clk);
			hold_cycles++;
		end
		receiver_hold = 1'b0;
	end

	initial begin
		alu_op_t op;
		logic [31:0] edge_vals[6];
		edge_vals = '{S32_MAX, S32_MIN, 32'd0, 32'd1, 32'hffff_ffff, 32'd256};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int c = 0; c <= 10; c++)
			pending_ops.push_back({4'(c), edge_vals[c % 6], edge_vals[(c + 1) % 6]});
		pending_ops.push_back({CMD_DIV, 32'd256, 32'd0});
		pending_ops.push_back({CMD_DIV, S32_MIN, 32'hffff_ffff});
		pending_ops.push_back({CMD_MUL, S32_MIN, S32_MIN});
		pending_ops.push_back({CMD_MUL, 32'h0000_0180, 32'hffff_ff80});
		pending_ops.push_back({CMD_DIV, 32'd1, 32'd512});
		pending_ops.push_back({CMD_INC, S32_MAX, 32'd0});
		pending_ops.push_back({CMD_DEC, S32_MIN, 32'd0});
		pending_ops.push_back({CMD_FROM_INT, 32'hff80_0000, 32'd0});
		pending_ops.push_back({CMD_TO_INT, 32'hffff_ff01, 32'd0});
		pending_ops.push_back({CMD_CMP, 32'd5, 32'd5});
		pending_ops.push_back({4'd15, 32'd7, 32'd9});
		pending_ops.push_back({4'd11, S32_MAX, S32_MAX});
		for (int i = 0; i < N_RANDOM; i++) begin
			op.cmd = $urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			op.a = rand_operand();
			op.b = $urandom_range(0, 15) == 0 ? 32'd0 : rand_operand();
			pending_ops.push_back(op);
			// sender pause until everything has drained
			if (i == 350) begin
				wait (pending_ops.size() == 0);
				sender_hold = 1'b1;
				wait (expected_results.size() == 0);
				sender_hold = 1'b0;
			end
		end
		wait (pending_ops.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (FB + 60) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done || cycles >= CYCLE_LIMIT);
		if (stim_done && mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
